// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/ttdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttdt_pkg
// Types and codes shared by the task delay table controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttdt_pkg;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_TAKE = 2'd2,
		CMD_RSVD = 2'd3
	} cmd_e_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_COOP = 2'd1,
		EV_FIRE = 2'd2,
		EV_DONE = 2'd3
	} ev_e_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH,
		ST_EXEC
	} state_e_t;

	typedef struct packed {
		logic valid;
		logic coop;
		logic [15:0] delay;
		logic [15:0] period;
		logic [7:0] runs;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic walk_step;
		logic finish;
		logic exec;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic walk_done;
	} ctl_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tick_task_delay_table_core.sv =====
// ----------------------------------------------------------------------------
// tick_task_delay_table_core
// Task delay table of a hybrid time-triggered scheduler, tick update engine.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start high and busy low.
//   command selects tick, load/clear slot or take one cooperative run.
//   Results leave on out_slot/event_res/run_count/last, marked by res_valid
//   for exactly one cycle each; the receiver cannot stall them.
//   A tick walks the slots one per cycle and holds each due result until the
//   next due slot or the end of the walk so that last can be marked; the walk
//   counter steps through the slot table, then the finish state closes the
//   beat before the next accept. The last result of a tick shows in the cycle
//   busy drops; earlier ones show during the walk.
//   Load and take pass through the exec state; the single result shows as busy drops.
//   A tick with nothing due gives one empty result with last set.
//   Reset (arst_n low) clears every slot, the sequencer and the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tick_task_delay_table_core #(
	parameter int TASK_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [2:0]  slot,
	input  logic [15:0] start_delay,
	input  logic [15:0] repeat_period,
	input  logic        cooperative,
	input  logic        enable,
	output logic        res_valid,
	output logic [2:0]  out_slot,
	output logic [1:0]  event_res,
	output logic [7:0]  run_count,
	output logic        last
);

	ttdt_pkg::ctl_cmd_t ctl_cmd;
	ttdt_pkg::ctl_sts_t ctl_sts;

	ttdt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (ctl_sts),
		.cmd     (ctl_cmd),
		.busy    (busy)
	);

	ttdt_dp #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (ctl_cmd),
		.sts           (ctl_sts),
		.command       (command),
		.slot          (slot),
		.start_delay   (start_delay),
		.repeat_period (repeat_period),
		.cooperative   (cooperative),
		.enable        (enable),
		.res_valid     (res_valid),
		.out_slot      (out_slot),
		.event_res     (event_res),
		.run_count     (run_count),
		.last          (last)
	);

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_close_last, clk, arst_n, ctl_cmd.finish || ctl_cmd.exec, res_valid && last)
	`ASSERT_IMPLY(a_more_busy, clk, arst_n, res_valid && !last, busy)
	`ASSERT_IMPLY(a_walk_busy, clk, arst_n, ctl_cmd.walk_step, busy && !ctl_cmd.capture)

endmodule

`default_nettype wire

// ===== hw/rtl/ttdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttdt_ctrl
// Sequencer: accepts a command, walks the table for a tick, closes the beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttdt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          command,
	input  ttdt_pkg::ctl_sts_t  sts,
	output ttdt_pkg::ctl_cmd_t  cmd,
	output logic                busy
);

	ttdt_pkg::state_e_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ttdt_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					if (command == ttdt_pkg::CMD_TICK) begin
						state_d = ttdt_pkg::ST_WALK;
					end else begin
						state_d = ttdt_pkg::ST_EXEC;
					end
				end
			end
			ttdt_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_done) begin
					state_d = ttdt_pkg::ST_FINISH;
				end
			end
			ttdt_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ttdt_pkg::ST_IDLE;
			end
			ttdt_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ttdt_pkg::ST_IDLE;
			end
			default: begin
				state_d = ttdt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ttdt_dp.sv =====
// ----------------------------------------------------------------------------
// ttdt_dp
// Slot table, walk counter, pending-result holder and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttdt_dp #(
	parameter int TASK_SLOTS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ttdt_pkg::ctl_cmd_t  cmd,
	output ttdt_pkg::ctl_sts_t  sts,
	input  logic [1:0]          command,
	input  logic [2:0]          slot,
	input  logic [15:0]         start_delay,
	input  logic [15:0]         repeat_period,
	input  logic                cooperative,
	input  logic                enable,
	output logic                res_valid,
	output logic [2:0]          out_slot,
	output logic [1:0]          event_res,
	output logic [7:0]          run_count,
	output logic                last
);

	localparam int SLOT_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

	ttdt_pkg::entry_t tbl_q [TASK_SLOTS];

	ttdt_pkg::cmd_e_t  cmd_q;
	logic [2:0]        slot_q;
	logic [15:0]       sd_q;
	logic [15:0]       rp_q;
	logic              co_q;
	logic              en_q;
	logic [SLOT_W-1:0] idx_q;

	logic              pend_valid_q;
	logic [2:0]        pend_slot_q;
	ttdt_pkg::ev_e_t   pend_ev_q;
	logic [7:0]        pend_runs_q;

	logic              res_valid_q;
	logic [2:0]        res_slot_q;
	logic [1:0]        res_ev_q;
	logic [7:0]        res_runs_q;
	logic              res_last_q;

	logic [SLOT_W-1:0] addr;
	logic              slot_ok;
	ttdt_pkg::entry_t  cur;
	ttdt_pkg::entry_t  wdata;
	logic              we;
	logic              due;
	ttdt_pkg::ev_e_t   due_ev;

	logic              emit;
	logic [2:0]        e_slot;
	ttdt_pkg::ev_e_t   e_ev;
	logic [7:0]        e_runs;
	logic              e_last;

	assign slot_ok = (32'(slot_q) < TASK_SLOTS);
	assign addr    = cmd.exec ? SLOT_W'(slot_q) : idx_q;
	assign cur     = tbl_q[addr];
	assign sts.walk_done = (idx_q == SLOT_W'(TASK_SLOTS - 1));

	always_comb begin
		we     = 1'b0;
		wdata  = cur;
		due    = 1'b0;
		due_ev = ttdt_pkg::EV_NONE;
		emit   = 1'b0;
		e_slot = 3'(idx_q);
		e_ev   = ttdt_pkg::EV_NONE;
		e_runs = 8'd0;
		e_last = 1'b0;

		if (cmd.walk_step && cur.valid) begin
			we = 1'b1;
			if (cur.delay == 16'd0) begin
				due = 1'b1;
				if (cur.coop) begin
					wdata.runs = cur.runs + 8'd1;
					due_ev     = ttdt_pkg::EV_COOP;
				end else begin
					wdata.runs = cur.runs - 8'd1;
					due_ev     = ttdt_pkg::EV_FIRE;
					if (cur.period == 16'd0) begin
						wdata.valid = 1'b0;
					end
				end
				if (cur.period != 16'd0) begin
					wdata.delay = cur.period;
				end
			end else begin
				wdata.delay = cur.delay - 16'd1;
			end
		end

		// flush the held result once a later one shows it was not the final beat
		if (cmd.walk_step && due && pend_valid_q) begin
			emit   = 1'b1;
			e_slot = pend_slot_q;
			e_ev   = pend_ev_q;
			e_runs = pend_runs_q;
		end

		if (cmd.finish) begin
			emit   = 1'b1;
			e_last = 1'b1;
			if (pend_valid_q) begin
				e_slot = pend_slot_q;
				e_ev   = pend_ev_q;
				e_runs = pend_runs_q;
			end else begin
				e_slot = 3'd0;
			end
		end

		if (cmd.exec) begin
			emit   = 1'b1;
			e_last = 1'b1;
			e_slot = slot_q;
			if (slot_ok) begin
				case (cmd_q)
					ttdt_pkg::CMD_LOAD: begin
						we           = 1'b1;
						wdata.valid  = en_q;
						wdata.coop   = en_q & co_q;
						wdata.delay  = en_q ? sd_q : 16'd0;
						wdata.period = en_q ? rp_q : 16'd0;
						wdata.runs   = 8'd0;
						e_ev         = ttdt_pkg::EV_DONE;
					end
					ttdt_pkg::CMD_TAKE: begin
						if (cur.valid && cur.coop && cur.runs != 8'd0) begin
							we         = 1'b1;
							wdata.runs = cur.runs - 8'd1;
							if (cur.period == 16'd0) begin
								wdata.valid = 1'b0;
							end
							e_ev   = ttdt_pkg::EV_DONE;
							e_runs = cur.runs - 8'd1;
						end else begin
							e_runs = cur.runs;
						end
					end
					default: begin
						e_ev = ttdt_pkg::EV_NONE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				tbl_q[i] <= '0;
			end
		end else if (we) begin
			tbl_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= ttdt_pkg::cmd_e_t'(command);
			slot_q <= slot;
			sd_q   <= start_delay;
			rp_q   <= repeat_period;
			co_q   <= cooperative;
			en_q   <= enable;
		end
		if (cmd.walk_step && due) begin
			pend_slot_q <= 3'(idx_q);
			pend_ev_q   <= due_ev;
			pend_runs_q <= wdata.runs;
		end
		if (emit) begin
			res_slot_q <= e_slot;
			res_ev_q   <= e_ev;
			res_runs_q <= e_runs;
			res_last_q <= e_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= emit;
			if (cmd.capture) begin
				idx_q        <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.walk_step) begin
				idx_q <= idx_q + SLOT_W'(1);
				if (due) begin
					pend_valid_q <= 1'b1;
				end
			end
		end
	end

	assign res_valid = res_valid_q;
	assign out_slot  = res_slot_q;
	assign event_res = res_ev_q;
	assign run_count = res_runs_q;
	assign last      = res_last_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tick_task_delay_table_core: directed command beats
// followed by random traffic, each result checked against an in-bench
// scheduler table kept in step with every accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int SLOTS = 8;

	typedef struct packed {
		logic [2:0]       slot;
		ttdt_pkg::ev_e_t  ev;
		logic [7:0]       runs;
		logic             last;
	} sched_event_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [2:0]  slot;
	logic [15:0] start_delay;
	logic [15:0] repeat_period;
	logic        cooperative;
	logic        enable;
	logic        res_valid;
	logic [2:0]  out_slot;
	logic [1:0]  event_res;
	logic [7:0]  run_count;
	logic        last;

	logic        tbl_valid [SLOTS];
	logic        tbl_coop [SLOTS];
	logic [15:0] tbl_delay [SLOTS];
	logic [15:0] tbl_period [SLOTS];
	logic [7:0]  tbl_runs [SLOTS];

	sched_event_t sched_events_q[$];
	sched_event_t want;

	int mismatch_count = 0;
	int results_seen = 0;
	int ticks_sent = 0;
	int loads_sent = 0;
	int takes_sent = 0;
	int other_sent = 0;
	int fires_seen = 0;
	int burst_left = 0;

	tick_task_delay_table_core #(
		.TASK_SLOTS(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.slot(slot),
		.start_delay(start_delay),
		.repeat_period(repeat_period),
		.cooperative(cooperative),
		.enable(enable),
		.res_valid(res_valid),
		.out_slot(out_slot),
		.event_res(event_res),
		.run_count(run_count),
		.last(last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic void clear_entry(int i);
		tbl_valid[i] = 1'b0;
		tbl_coop[i] = 1'b0;
		tbl_delay[i] = '0;
		tbl_period[i] = '0;
		tbl_runs[i] = '0;
	endfunction

	function automatic void advance_table(ttdt_pkg::cmd_e_t c, logic [2:0] s,
			logic [15:0] sd, logic [15:0] rp, logic co, logic en);
		sched_event_t e;
		int n;
		n = 0;
		case (c)
			ttdt_pkg::CMD_TICK: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (tbl_valid[i]) begin
						if (tbl_delay[i] == 16'd0) begin
							if (tbl_coop[i]) begin
								tbl_runs[i] = tbl_runs[i] + 8'd1;
								e.ev = ttdt_pkg::EV_COOP;
							end else begin
								tbl_runs[i] = tbl_runs[i] - 8'd1;
								e.ev = ttdt_pkg::EV_FIRE;
								if (tbl_period[i] == 16'd0)
									tbl_valid[i] = 1'b0;
							end
							if (tbl_period[i] != 16'd0)
								tbl_delay[i] = tbl_period[i];
							e.slot = 3'(i);
							e.runs = tbl_runs[i];
							e.last = 1'b0;
							sched_events_q.push_back(e);
							n++;
						end else begin
							tbl_delay[i] = tbl_delay[i] - 16'd1;
						end
					end
				end
				if (n == 0) begin
					sched_events_q.push_back('{3'd0, ttdt_pkg::EV_NONE, 8'd0, 1'b1});
				end else begin
					e = sched_events_q.pop_back();
					e.last = 1'b1;
					sched_events_q.push_back(e);
				end
			end
			ttdt_pkg::CMD_LOAD: begin
				clear_entry(s);
				if (en) begin
					tbl_valid[s] = 1'b1;
					tbl_coop[s] = co;
					tbl_delay[s] = sd;
					tbl_period[s] = rp;
				end
				sched_events_q.push_back('{s, ttdt_pkg::EV_DONE, tbl_runs[s], 1'b1});
			end
			ttdt_pkg::CMD_TAKE: begin
				if (tbl_valid[s] && tbl_coop[s] && tbl_runs[s] != 8'd0) begin
					tbl_runs[s] = tbl_runs[s] - 8'd1;
					if (tbl_period[s] == 16'd0)
						tbl_valid[s] = 1'b0;
					sched_events_q.push_back('{s, ttdt_pkg::EV_DONE, tbl_runs[s], 1'b1});
				end else begin
					sched_events_q.push_back('{s, ttdt_pkg::EV_NONE, tbl_runs[s], 1'b1});
				end
			end
			default: begin
				sched_events_q.push_back('{s, ttdt_pkg::EV_NONE, 8'd0, 1'b1});
			end
		endcase
	endfunction

	function automatic void note_mismatch(string what);
		if (mismatch_count < 10)
			$display({"%0t mismatch (%s): exp slot=%0d ev=%0d runs=%0d last=%0d,",
				" got slot=%0d ev=%0d runs=%0d last=%0d"},
				$realtime, what, want.slot, want.ev, want.runs, want.last,
				out_slot, event_res, run_count, last);
		mismatch_count++;
	endfunction

	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			results_seen++;
			if (event_res == ttdt_pkg::EV_FIRE)
				fires_seen++;
			if (sched_events_q.size() == 0) begin
				want = '0;
				note_mismatch("unexpected");
			end else begin
				want = sched_events_q.pop_front();
				if (out_slot !== want.slot || event_res !== want.ev
						|| run_count !== want.runs || last !== want.last)
					note_mismatch("field");
			end
		end
	end

	// bursts of back-to-back beats separated by random gaps
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 8);
			if (gap > 0) begin
				start = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_beat(ttdt_pkg::cmd_e_t c, logic [2:0] s, logic [15:0] sd,
			logic [15:0] rp, logic co, logic en);
		command = c;
		slot = s;
		start_delay = sd;
		repeat_period = rp;
		cooperative = co;
		enable = en;
		start = 1'b1;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		advance_table(c, s, sd, rp, co, en);
		case (c)
			ttdt_pkg::CMD_TICK: ticks_sent++;
			ttdt_pkg::CMD_LOAD: loads_sent++;
			ttdt_pkg::CMD_TAKE: takes_sent++;
			default: other_sent++;
		endcase
		@(negedge clk);
		pace();
	endtask

	task automatic test_empty_table();
		send_beat(ttdt_pkg::CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0, 1'b0);
		send_beat(ttdt_pkg::CMD_TAKE, 3'd4, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		send_beat(ttdt_pkg::CMD_RSVD, 3'd6, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
	endtask

	task automatic test_one_shot_and_wrap();
		send_beat(ttdt_pkg::CMD_LOAD, 3'd0, 16'd0, 16'd0, 1'b0, 1'b1);
		send_beat(ttdt_pkg::CMD_LOAD, 3'd7, 16'd0, 16'd0, 1'b1, 1'b1);
		send_beat(ttdt_pkg::CMD_LOAD, 3'd3, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
		send_beat(ttdt_pkg::CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0, 1'b0);
		send_beat(ttdt_pkg::CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0, 1'b0);
	endtask

	task automatic test_cooperative_take();
		send_beat(ttdt_pkg::CMD_TAKE, 3'd7, 16'd0, 16'd0, 1'b0, 1'b0);
		send_beat(ttdt_pkg::CMD_TAKE, 3'd7, 16'd0, 16'd0, 1'b0, 1'b0);
		send_beat(ttdt_pkg::CMD_TAKE, 3'd7, 16'd0, 16'd0, 1'b0, 1'b0);
		send_beat(ttdt_pkg::CMD_TAKE, 3'd3, 16'd0, 16'd0, 1'b0, 1'b0);
	endtask

	task automatic test_full_table_tick();
		for (int i = 0; i < SLOTS; i++)
			send_beat(ttdt_pkg::CMD_LOAD, 3'(i), 16'd0, 16'd1, i[0], 1'b1);
		repeat (3)
			send_beat(ttdt_pkg::CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0, 1'b0);
	endtask

	task automatic test_delete_slot();
		send_beat(ttdt_pkg::CMD_LOAD, 3'd2, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
		send_beat(ttdt_pkg::CMD_TICK, 3'd0, 16'd0, 16'd0, 1'b0, 1'b0);
	endtask

	task automatic test_random_traffic(int beats);
		int r;
		logic [15:0] sd;
		logic [15:0] rp;
		for (int k = 0; k < beats; k++) begin
			r = $urandom_range(0, 99);
			// mostly short delays and periods so slots come due often
			sd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
			rp = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
			if (r < 45)
				send_beat(ttdt_pkg::CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom), 1'($urandom));
			else if (r < 75)
				send_beat(ttdt_pkg::CMD_LOAD, 3'($urandom), sd, rp, 1'($urandom),
					$urandom_range(0, 9) != 0);
			else if (r < 93)
				send_beat(ttdt_pkg::CMD_TAKE, 3'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom), 1'($urandom));
			else
				send_beat(ttdt_pkg::CMD_RSVD, 3'($urandom), 16'($urandom), 16'($urandom),
					1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		start = 1'b0;
		command = ttdt_pkg::CMD_TICK;
		slot = '0;
		start_delay = '0;
		repeat_period = '0;
		cooperative = 1'b0;
		enable = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			clear_entry(i);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		test_one_shot_and_wrap();
		test_cooperative_take();
		test_full_table_tick();
		test_delete_slot();
		test_random_traffic(85);

		start = 1'b0;
		guard = 0;
		while (sched_events_q.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (2 * SLOTS + 4) @(posedge clk);
		if (sched_events_q.size() != 0) begin
			$display("%0d expected results never arrived", sched_events_q.size());
			mismatch_count += sched_events_q.size();
		end

		$display("Sent %0d ticks, %0d loads, %0d takes, %0d reserved commands",
			ticks_sent, loads_sent, takes_sent, other_sent);
		$display("Checked %0d results (%0d pre-emptive fires), %0d mismatches",
			results_seen, fires_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
